[rtl/core/kabf_pkg.sv]
// Shared types and constants for the angle/bias Kalman filter.
// No dependencies; used by the divider, the controller, the datapath, the top level and the testbench.
`default_nettype none

package kabf_pkg;

    localparam int DT_FRAC = 24;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [30:0] RST_ANGLE_NOISE = 31'd16777;
    localparam logic [30:0] RST_BIAS_NOISE  = 31'd50332;
    localparam logic [30:0] RST_MEAS_NOISE  = 31'd503316;

    typedef enum logic [1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        STEP_NONE = 5'd0,
        STEP_INIT = 5'd1,
        STEP_P0   = 5'd2,
        STEP_P1   = 5'd3,
        STEP_P2   = 5'd4,
        STEP_P3   = 5'd5,
        STEP_P4   = 5'd6,
        STEP_P5   = 5'd7,
        STEP_SUM  = 5'd8,
        STEP_D0   = 5'd9,
        STEP_D0W  = 5'd10,
        STEP_D1   = 5'd11,
        STEP_D1W  = 5'd12,
        STEP_U0   = 5'd13,
        STEP_U1   = 5'd14,
        STEP_U2   = 5'd15,
        STEP_U3   = 5'd16,
        STEP_U4   = 5'd17,
        STEP_U5   = 5'd18,
        STEP_U6   = 5'd19
    } step_t;

    typedef struct packed {
        logic  capture;
        logic  load_out;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic need_init;
        logic div_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < 68'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/kabf_div.sv]
// Sequential signed divider for the Kalman gains: (num * 2^FRAC) / den,
// truncated toward zero and saturated to 32 bits. One quotient bit per cycle.
// Depends on kabf_pkg.
`default_nettype none

module kabf_div #(
    parameter int FRAC = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [32:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam int NW = 32 + FRAC;

    logic [31:0]   num_abs;
    logic [32:0]   den_abs;
    logic [NW-1:0] num_sh;
    logic [33:0]   trial;
    logic          ovf;

    logic [33:0]   rem_reg;
    logic [31:0]   q_reg;
    logic [32:0]   den_reg;
    logic [4:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic          zero_reg;
    logic          ovf_reg;

    always_comb begin
        num_abs = num[31] ? (~num + 32'd1) : num;
        den_abs = den[32] ? (~den + 33'd1) : den;
        num_sh  = {num_abs, {FRAC{1'b0}}};
        ovf     = 34'(num_sh[NW-1:32]) >= {1'b0, den_abs};
        trial   = {rem_reg[32:0], q_reg[31]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= 34'(num_sh[NW-1:32]);
            q_reg    <= num_sh[31:0];
            den_reg  <= den_abs;
            neg_reg  <= num[31] ^ den[32];
            zero_reg <= (den == 33'sd0);
            ovf_reg  <= ovf;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[30:0], 1'b1};
            end else begin
                rem_reg <= trial;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (zero_reg) begin
            quot = '0;
        end else if (ovf_reg) begin
            quot = neg_reg ? kabf_pkg::SAT_MIN : kabf_pkg::SAT_MAX;
        end else if (neg_reg) begin
            quot = (q_reg > 32'h8000_0000) ? kabf_pkg::SAT_MIN : (~q_reg + 32'd1);
        end else begin
            quot = (q_reg > 32'h7FFF_FFFF) ? kabf_pkg::SAT_MAX : q_reg;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/core/kabf_dp.sv]
// Datapath of the Kalman filter: state, noise registers, shared multiplier
// and the gain divider. Driven step by step by kabf_ctrl; uses kabf_pkg, kabf_div.
`default_nettype none

module kabf_dp #(
    parameter int COV_FRAC_BITS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire kabf_pkg::cmd_t     cmd,
    output kabf_pkg::status_t       status,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_wdata,
    input  wire logic signed [31:0] s_measured_angle,
    input  wire logic signed [31:0] s_gyro_rate,
    input  wire logic [23:0]        s_time_step,
    input  wire logic               s_restart,
    output logic signed [31:0]      m_filtered_angle,
    output logic signed [31:0]      m_bias_estimate
);

    localparam int C = COV_FRAC_BITS;
    localparam logic signed [65:0] DT_HALF = 66'sd1 <<< (kabf_pkg::DT_FRAC - 1);
    localparam logic signed [65:0] C_HALF  = 66'sd1 <<< (C - 1);
    localparam logic signed [67:0] ONE_C   = 68'sd1 <<< C;
    localparam logic signed [31:0] INIT_AA = kabf_pkg::sat32(68'sd10 <<< C);
    localparam logic signed [31:0] INIT_BB = kabf_pkg::sat32(68'sd1 <<< C);

    logic [30:0] qa_reg, qb_reg, r_reg;

    logic signed [31:0] meas_reg, gyro_reg;
    logic [23:0]        dt_reg;
    logic               restart_reg;
    logic               primed_reg;

    logic signed [31:0] ang_reg, bias_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [31:0] innov_reg, k0_reg, k1_reg, m_reg;
    logic signed [32:0] s_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] out_ang_reg, out_bias_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] rd_v, rc_v;
    logic signed [67:0] rd, rc;
    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_quot;

    function automatic logic signed [67:0] sx32(input logic signed [31:0] v);
        return {{36{v[31]}}, v};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= kabf_pkg::RST_ANGLE_NOISE;
            qb_reg <= kabf_pkg::RST_BIAS_NOISE;
            r_reg  <= kabf_pkg::RST_MEAS_NOISE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kabf_pkg::CFG_ANGLE_NOISE: qa_reg <= cfg_wdata;
                kabf_pkg::CFG_BIAS_NOISE:  qb_reg <= cfg_wdata;
                kabf_pkg::CFG_MEAS_NOISE:  r_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = aa_reg;
        case (cmd.step)
            kabf_pkg::STEP_P0: begin
                mul_a = {gyro_reg[31], gyro_reg} - {bias_reg[31], bias_reg};
                mul_b = {9'd0, dt_reg};
            end
            kabf_pkg::STEP_P1: begin
                mul_a = {ba_reg[31], ba_reg};
                mul_b = {9'd0, dt_reg};
            end
            kabf_pkg::STEP_P2: begin
                mul_a = {bb_reg[31], bb_reg};
                mul_b = {9'd0, dt_reg};
            end
            kabf_pkg::STEP_P3: begin
                mul_a = {2'd0, qb_reg};
                mul_b = {9'd0, dt_reg};
            end
            kabf_pkg::STEP_P4: begin
                mul_a = {ab_reg[31], ab_reg};
                mul_b = {9'd0, dt_reg};
            end
            kabf_pkg::STEP_D0: begin
                div_start = 1'b1;
            end
            kabf_pkg::STEP_D1: begin
                div_start = 1'b1;
                div_num   = ba_reg;
            end
            kabf_pkg::STEP_U0: begin
                mul_a = {k0_reg[31], k0_reg};
                mul_b = {innov_reg[31], innov_reg};
            end
            kabf_pkg::STEP_U1: begin
                mul_a = {k1_reg[31], k1_reg};
                mul_b = {innov_reg[31], innov_reg};
            end
            kabf_pkg::STEP_U2: begin
                mul_a = {k1_reg[31], k1_reg};
                mul_b = {aa_reg[31], aa_reg};
            end
            kabf_pkg::STEP_U3: begin
                mul_a = {k1_reg[31], k1_reg};
                mul_b = {ab_reg[31], ab_reg};
            end
            kabf_pkg::STEP_U4: begin
                mul_a = {m_reg[31], m_reg};
                mul_b = {aa_reg[31], aa_reg};
            end
            kabf_pkg::STEP_U5: begin
                mul_a = {m_reg[31], m_reg};
                mul_b = {ab_reg[31], ab_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        rd_v = (prod_reg + DT_HALF) >>> kabf_pkg::DT_FRAC;
        rc_v = (prod_reg + C_HALF) >>> C;
        rd   = {{2{rd_v[65]}}, rd_v};
        rc   = {{2{rc_v[65]}}, rc_v};
    end

    kabf_div #(
        .FRAC (C)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (s_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (cmd.step == kabf_pkg::STEP_INIT) begin
            primed_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture) begin
            meas_reg    <= s_measured_angle;
            gyro_reg    <= s_gyro_rate;
            dt_reg      <= s_time_step;
            restart_reg <= s_restart;
        end
        if (cmd.load_out) begin
            out_ang_reg  <= ang_reg;
            out_bias_reg <= bias_reg;
        end
        case (cmd.step)
            kabf_pkg::STEP_INIT: begin
                ang_reg  <= meas_reg;
                bias_reg <= '0;
                aa_reg   <= INIT_AA;
                ab_reg   <= '0;
                ba_reg   <= '0;
                bb_reg   <= INIT_BB;
            end
            kabf_pkg::STEP_P1: ang_reg <= kabf_pkg::sat32(sx32(ang_reg) + rd);
            kabf_pkg::STEP_P2: aa_reg  <= kabf_pkg::sat32(sx32(aa_reg) - rd);
            kabf_pkg::STEP_P3: ab_reg  <= kabf_pkg::sat32(sx32(ab_reg) - rd);
            kabf_pkg::STEP_P4: bb_reg  <= kabf_pkg::sat32(sx32(bb_reg) + rd);
            kabf_pkg::STEP_P5: begin
                aa_reg    <= kabf_pkg::sat32(sx32(aa_reg) - rd + 68'(qa_reg));
                innov_reg <= kabf_pkg::sat32(sx32(meas_reg) - sx32(ang_reg));
            end
            kabf_pkg::STEP_SUM: s_reg <= {aa_reg[31], aa_reg} + {2'd0, r_reg};
            kabf_pkg::STEP_D0W: begin
                if (div_done) begin
                    k0_reg <= div_quot;
                end
            end
            kabf_pkg::STEP_D1W: begin
                if (div_done) begin
                    k1_reg <= div_quot;
                end
            end
            kabf_pkg::STEP_U0: m_reg    <= kabf_pkg::sat32(ONE_C - sx32(k0_reg));
            kabf_pkg::STEP_U1: ang_reg  <= kabf_pkg::sat32(sx32(ang_reg) + rc);
            kabf_pkg::STEP_U2: bias_reg <= kabf_pkg::sat32(sx32(bias_reg) + rc);
            kabf_pkg::STEP_U3: ba_reg   <= kabf_pkg::sat32(sx32(ba_reg) - rc);
            kabf_pkg::STEP_U4: bb_reg   <= kabf_pkg::sat32(sx32(bb_reg) - rc);
            kabf_pkg::STEP_U5: aa_reg   <= kabf_pkg::sat32(rc);
            kabf_pkg::STEP_U6: ab_reg   <= kabf_pkg::sat32(rc);
            default: ;
        endcase
    end

    assign status.need_init = !primed_reg || restart_reg;
    assign status.div_done  = div_done;
    assign m_filtered_angle = out_ang_reg;
    assign m_bias_estimate  = out_bias_reg;

endmodule

`default_nettype wire

[rtl/core/kabf_ctrl.sv]
// Sequencer of the Kalman filter: one-hot state machine that walks the
// datapath through predict, gain and update, and owns both handshakes. Uses kabf_pkg.
`default_nettype none

module kabf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire kabf_pkg::status_t status,
    output kabf_pkg::cmd_t         cmd
);

    typedef enum logic [21:0] {
        ST_IDLE = 22'h000001,
        ST_CHK  = 22'h000002,
        ST_INIT = 22'h000004,
        ST_P0   = 22'h000008,
        ST_P1   = 22'h000010,
        ST_P2   = 22'h000020,
        ST_P3   = 22'h000040,
        ST_P4   = 22'h000080,
        ST_P5   = 22'h000100,
        ST_SUM  = 22'h000200,
        ST_D0   = 22'h000400,
        ST_D0W  = 22'h000800,
        ST_D1   = 22'h001000,
        ST_D1W  = 22'h002000,
        ST_U0   = 22'h004000,
        ST_U1   = 22'h008000,
        ST_U2   = 22'h010000,
        ST_U3   = 22'h020000,
        ST_U4   = 22'h040000,
        ST_U5   = 22'h080000,
        ST_U6   = 22'h100000,
        ST_DONE = 22'h200000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.step     = kabf_pkg::STEP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK:  state_next = status.need_init ? ST_INIT : ST_P0;
            ST_INIT: begin cmd.step = kabf_pkg::STEP_INIT; state_next = ST_DONE; end
            ST_P0:   begin cmd.step = kabf_pkg::STEP_P0;   state_next = ST_P1;   end
            ST_P1:   begin cmd.step = kabf_pkg::STEP_P1;   state_next = ST_P2;   end
            ST_P2:   begin cmd.step = kabf_pkg::STEP_P2;   state_next = ST_P3;   end
            ST_P3:   begin cmd.step = kabf_pkg::STEP_P3;   state_next = ST_P4;   end
            ST_P4:   begin cmd.step = kabf_pkg::STEP_P4;   state_next = ST_P5;   end
            ST_P5:   begin cmd.step = kabf_pkg::STEP_P5;   state_next = ST_SUM;  end
            ST_SUM:  begin cmd.step = kabf_pkg::STEP_SUM;  state_next = ST_D0;   end
            ST_D0:   begin cmd.step = kabf_pkg::STEP_D0;   state_next = ST_D0W;  end
            ST_D0W: begin
                cmd.step = kabf_pkg::STEP_D0W;
                if (status.div_done) begin
                    state_next = ST_D1;
                end
            end
            ST_D1:   begin cmd.step = kabf_pkg::STEP_D1;   state_next = ST_D1W;  end
            ST_D1W: begin
                cmd.step = kabf_pkg::STEP_D1W;
                if (status.div_done) begin
                    state_next = ST_U0;
                end
            end
            ST_U0:   begin cmd.step = kabf_pkg::STEP_U0;   state_next = ST_U1;   end
            ST_U1:   begin cmd.step = kabf_pkg::STEP_U1;   state_next = ST_U2;   end
            ST_U2:   begin cmd.step = kabf_pkg::STEP_U2;   state_next = ST_U3;   end
            ST_U3:   begin cmd.step = kabf_pkg::STEP_U3;   state_next = ST_U4;   end
            ST_U4:   begin cmd.step = kabf_pkg::STEP_U4;   state_next = ST_U5;   end
            ST_U5:   begin cmd.step = kabf_pkg::STEP_U5;   state_next = ST_U6;   end
            ST_U6:   begin cmd.step = kabf_pkg::STEP_U6;   state_next = ST_DONE; end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while waiting");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result not presented");
    a_accept_checks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CHK))
        else $error("transfer did not start a step");
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_D0W || state_reg == ST_D1W))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

[rtl/core/kalman_angle_bias_filter_unit.sv]
// Top level of the two-state angle/bias Kalman filter.
// Depends on kabf_pkg, kabf_ctrl, kabf_dp (which holds kabf_div).
//
// Usage:
//   Input channel s_*: measured angle (Q16.16), gyro rate, time step (Q0.24)
//   and a restart flag, one transfer per filter step.
//   Result channel m_*: filtered angle and bias estimate, one transfer per item.
//   Config port cfg_*: write enable, index 0..2 (angle noise, bias noise,
//   measurement noise), 31-bit data; write only while the block is idle.
//
// Sequencing: one item at a time. The time of a normal update is dominated by the
// two gain divisions on the shared radix-2 divider (start, 32 quotient bits, finish),
// plus 11 multiplier steps on one 33x33 multiplier. A first item or a restart
// passes only the check, init and done states. The next transfer can be taken in
// the cycle after the result is loaded; no new item is taken before then.
// s_ready is high whenever the sequencer is idle, even while a result waits.
// If the receiver stalls, the finished result holds in the output register
// and the next item stalls in its final step until that register frees.
// Reset (aresetn low, synchronous) clears handshakes and primed flag and loads the default noise.
`default_nettype none

module kalman_angle_bias_filter_unit #(
    parameter int COV_FRAC_BITS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_measured_angle,
    input  wire logic signed [31:0] s_gyro_rate,
    input  wire logic [23:0]        s_time_step,
    input  wire logic               s_restart,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_filtered_angle,
    output logic signed [31:0]      m_bias_estimate,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_wdata
);

    kabf_pkg::cmd_t    cmd;
    kabf_pkg::status_t status;

    kabf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kabf_dp #(
        .COV_FRAC_BITS (COV_FRAC_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_measured_angle (s_measured_angle),
        .s_gyro_rate      (s_gyro_rate),
        .s_time_step      (s_time_step),
        .s_restart        (s_restart),
        .m_filtered_angle (m_filtered_angle),
        .m_bias_estimate  (m_bias_estimate)
    );

endmodule

`default_nettype wire

[bench/tb_kalman_angle_bias_filter_unit.sv]
// Self-checking testbench for kalman_angle_bias_filter_unit: directed and random filter steps
// checked against a fixed-point predictor of the angle/bias filter kept in a scoreboard class.
// Depends on kabf_pkg and the RTL top level only.
`default_nettype none

module tb_kalman_angle_bias_filter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COV_BITS = 24;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
    localparam longint LIM_MAX = 64'sd2147483647;
    localparam longint LIM_MIN = -64'sd2147483648;

    class kalman_scoreboard;
        typedef struct {
            logic signed [31:0] angle;
            logic signed [31:0] bias;
        } estimate_t;

        longint    q_angle, q_bias, r_meas;
        longint    angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
        bit        primed;
        estimate_t estimates_q[$];
        int        mismatches, results_seen, inputs_seen, restarts_seen, zero_s_seen;

        function new();
            q_angle = kabf_pkg::RST_ANGLE_NOISE;
            q_bias  = kabf_pkg::RST_BIAS_NOISE;
            r_meas  = kabf_pkg::RST_MEAS_NOISE;
            angle_est = 0; bias_est = 0;
            cov_aa = 0; cov_ab = 0; cov_ba = 0; cov_bb = 0;
            primed = 0;
            mismatches = 0; results_seen = 0; inputs_seen = 0;
            restarts_seen = 0; zero_s_seen = 0;
        endfunction

        function longint clip(longint v);
            if (v > LIM_MAX) return LIM_MAX;
            if (v < LIM_MIN) return LIM_MIN;
            return v;
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint kgain(longint num, longint den);
            if (den == 0) return 0;
            return clip((num <<< COV_BITS) / den);
        endfunction

        function void set_noise(logic [1:0] idx, logic [30:0] val);
            case (idx)
                kabf_pkg::CFG_ANGLE_NOISE: q_angle = val;
                kabf_pkg::CFG_BIAS_NOISE:  q_bias = val;
                kabf_pkg::CFG_MEAS_NOISE:  r_meas = val;
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [31:0] meas_in, logic signed [31:0] gyro_in,
                                 logic [23:0] dt_in, logic restart_in);
            longint meas, gyro, dt, ang, bias, aa, ab, ba, bb, t00, t01, innov, s, k0, k1, m;
            estimate_t e;
            meas = meas_in;
            gyro = gyro_in;
            dt = dt_in;
            inputs_seen++;
            if (!primed || restart_in) begin
                restarts_seen++;
                angle_est = meas;
                bias_est = 0;
                cov_aa = clip(64'sd10 <<< COV_BITS);
                cov_ab = 0;
                cov_ba = 0;
                cov_bb = clip(64'sd1 <<< COV_BITS);
                primed = 1;
            end else begin
                ang = angle_est; bias = bias_est;
                aa = cov_aa; ab = cov_ab; ba = cov_ba; bb = cov_bb;
                ang = clip(ang + round_shift((gyro - bias) * dt, kabf_pkg::DT_FRAC));
                t00 = clip(aa - round_shift(dt * ba, kabf_pkg::DT_FRAC));
                t01 = clip(ab - round_shift(dt * bb, kabf_pkg::DT_FRAC));
                aa = clip(t00 - round_shift(dt * t01, kabf_pkg::DT_FRAC) + q_angle);
                ab = t01;
                bb = clip(bb + round_shift(q_bias * dt, kabf_pkg::DT_FRAC));
                innov = clip(meas - ang);
                s = aa + r_meas;
                if (s == 0) zero_s_seen++;
                k0 = kgain(aa, s);
                k1 = kgain(ba, s);
                ang = clip(ang + round_shift(k0 * innov, COV_BITS));
                bias = clip(bias + round_shift(k1 * innov, COV_BITS));
                m = clip((64'sd1 <<< COV_BITS) - k0);
                angle_est = ang;
                bias_est = bias;
                cov_aa = clip(round_shift(m * aa, COV_BITS));
                cov_ab = clip(round_shift(m * ab, COV_BITS));
                cov_ba = clip(ba - round_shift(k1 * aa, COV_BITS));
                cov_bb = clip(bb - round_shift(k1 * ab, COV_BITS));
            end
            e.angle = angle_est[31:0];
            e.bias = bias_est[31:0];
            estimates_q.push_back(e);
        endfunction

        function void check_result(logic signed [31:0] angle, logic signed [31:0] bias);
            estimate_t e;
            results_seen++;
            if (estimates_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result angle=%0d bias=%0d", angle, bias);
                return;
            end
            e = estimates_q.pop_front();
            if (angle !== e.angle || bias !== e.bias) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: angle exp %0d got %0d, bias exp %0d got %0d",
                             results_seen, e.angle, angle, e.bias, bias);
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_measured_angle = 0;
    logic signed [31:0] s_gyro_rate = 0;
    logic [23:0]        s_time_step = 0;
    logic               s_restart = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_filtered_angle;
    logic signed [31:0] m_bias_estimate;
    logic               cfg_we = 0;
    logic [1:0]         cfg_index = 0;
    logic [30:0]        cfg_wdata = 0;

    kalman_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;

    kalman_angle_bias_filter_unit dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_measured_angle, s_gyro_rate, s_time_step, s_restart);
            if (m_valid && m_ready)
                sb.check_result(m_filtered_angle, m_bias_estimate);
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_step(logic signed [31:0] meas, logic signed [31:0] gyro,
                             logic [23:0] dt, logic restart);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_measured_angle <= meas;
        s_gyro_rate <= gyro;
        s_time_step <= dt;
        s_restart <= restart;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.estimates_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_noise(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_noise(idx, val);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic random_step();
        logic signed [31:0] meas, gyro;
        logic [23:0] dt;
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            // typical IMU sample near the current estimate
            meas = sb.angle_est[31:0] + $signed($urandom_range(2 * 655360) - 655360);
            gyro = $signed($urandom_range(2 * 6553600) - 6553600);
            dt = 24'($urandom_range(335544));
        end else if (pick < 95) begin
            meas = $urandom;
            gyro = $urandom;
            dt = 24'($urandom);
        end else begin
            meas = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            gyro = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            dt = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
        end
        send_step(meas, gyro, dt, $urandom_range(99) < 3);
    endtask

    function automatic logic [30:0] random_noise(int kind);
        case (kind)
            0: return 31'h0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1000000));
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed steps at the reset noise values
        send_step(32'sd65536, 32'sd0, 24'd0, 0);
        send_step(32'sd70000, 32'sd13107, 24'd167772, 0);
        send_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF, 0);
        send_step(32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF, 0);
        send_step(32'sh8000_0000, 32'sh7FFF_FFFF, 24'h00_0001, 0);
        send_step(32'sd100, 32'sd0, 24'd0, 1);
        send_step(32'sd200, 32'sd50, 24'd1000, 0);
        send_step(32'sh7FFF_FFFF, 32'sh8000_0000, 24'hAA_AAAA, 1);
        send_step(32'sh5555_5555, 32'shAAAA_AAAA, 24'h55_5555, 0);
        send_step(-32'sd1, -32'sd1, 24'd16777, 0);
        drain();

        // zero measurement and angle noise drive S to zero
        write_noise(kabf_pkg::CFG_ANGLE_NOISE, 31'd0);
        write_noise(kabf_pkg::CFG_MEAS_NOISE, 31'd0);
        write_noise(kabf_pkg::CFG_BIAS_NOISE, 31'd0);
        send_step(32'sd1000, 32'sd0, 24'd0, 1);
        send_step(32'sd2000, 32'sd0, 24'd0, 0);
        send_step(32'sd3000, 32'sd77, 24'd0, 0);
        send_step(32'sd4000, 32'sd77, 24'd500, 0);
        drain();

        write_noise(kabf_pkg::CFG_ANGLE_NOISE, 31'h7FFF_FFFF);
        write_noise(kabf_pkg::CFG_BIAS_NOISE, 31'h7FFF_FFFF);
        write_noise(kabf_pkg::CFG_MEAS_NOISE, 31'h7FFF_FFFF);
        write_noise(CFG_UNUSED_IDX, 31'h1234_5678);
        send_step(32'sd0, 32'sd0, 24'hFF_FFFF, 0);
        send_step(32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF, 0);
        send_step(32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFF_FFFF, 0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            if (phase == 0) begin
                write_noise(kabf_pkg::CFG_ANGLE_NOISE, kabf_pkg::RST_ANGLE_NOISE);
                write_noise(kabf_pkg::CFG_BIAS_NOISE, kabf_pkg::RST_BIAS_NOISE);
                write_noise(kabf_pkg::CFG_MEAS_NOISE, kabf_pkg::RST_MEAS_NOISE);
            end else begin
                write_noise(kabf_pkg::CFG_ANGLE_NOISE, random_noise($urandom_range(7)));
                write_noise(kabf_pkg::CFG_BIAS_NOISE, random_noise($urandom_range(7)));
                write_noise(kabf_pkg::CFG_MEAS_NOISE, random_noise($urandom_range(7)));
            end
            for (int i = 0; i < 250; i++) random_step();
            drain();
        end

        if (sb.estimates_q.size() != 0) sb.mismatches++;
        $display("ran %0d filter steps (%0d initializations, %0d zero-S updates), %0d results",
                 sb.inputs_seen, sb.restarts_seen, sb.zero_s_seen, sb.results_seen);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
rtl/core/kabf_pkg.sv
rtl/core/kabf_div.sv
rtl/core/kabf_dp.sv
rtl/core/kabf_ctrl.sv
rtl/core/kalman_angle_bias_filter_unit.sv
bench/tb_kalman_angle_bias_filter_unit.sv
